/* rtl/otcb_pkg.sv */
// ----------------------------------------------------------------------------
// otcb_pkg
// shared types and constants of the one-shot timer and counter bank
// ----------------------------------------------------------------------------
package otcb_pkg;

  // bank sizes (1 to 32 each)
  localparam int TIMER_SLOTS   = 8;
  localparam int COUNTER_SLOTS = 8;

  // slot index widths and in-use count widths
  localparam int TIDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CIDX_W = (COUNTER_SLOTS > 1) ? $clog2(COUNTER_SLOTS) : 1;
  localparam int TCNT_W = $clog2(TIMER_SLOTS + 1);
  localparam int CCNT_W = $clog2(COUNTER_SLOTS + 1);

  // field widths
  localparam int REQ_W     = 3;
  localparam int SLOT_W    = 8;
  localparam int VALUE_W   = 16;
  localparam int ELAPSED_W = 8;

  // marks
  localparam logic [VALUE_W-1:0] IDLE_MARK = 16'hFFFF;
  localparam logic [SLOT_W-1:0]  NO_SLOT   = 8'hFF;

  // result kinds
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_EXPIRED = 1'b1;

  // command queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_NEW_TIMER     = 3'd0,
    REQ_START_TIMER   = 3'd1,
    REQ_STOP_TIMER    = 3'd2,
    REQ_NEW_COUNTER   = 3'd3,
    REQ_START_COUNTER = 3'd4,
    REQ_STOP_COUNTER  = 3'd5,
    REQ_READ_COUNTER  = 3'd6,
    REQ_TICK          = 3'd7
  } req_e_t;

  // classified command as held in the queue
  typedef struct packed {
    req_e_t                 req;
    logic [SLOT_W-1:0]      slot;
    logic [VALUE_W-1:0]     period;
    logic [ELAPSED_W-1:0]   elapsed;
    logic                   bad;        // addressed slot beyond its bank
    logic                   tick_live;  // tick with a nonzero amount
  } otcb_cmd_t;

endpackage

/* rtl/oneshot_timer_and_counter_bank_unit.sv */
// ----------------------------------------------------------------------------
// oneshot_timer_and_counter_bank_unit
// bank of one-shot down-timers and up-counters driven by one tick source
// ----------------------------------------------------------------------------
// usage
//   input channel (in_*): one request per transfer: allocate, start, stop or
//   read a timer/counter slot, or a tick carrying an elapsed amount
//   result channel (out_*): every non-tick request gives one result with
//   out_last set; a tick gives one out_kind=1 result per expired timer in
//   slot order, then a closing acknowledge with out_last set
// throughput
//   a request enters a two-entry command queue and moves on from there into
//   the result register; non-tick requests sustain one per cycle while the
//   receiver does not stall and no tick walk is running
//   a nonzero tick walks the timer slots one per cycle through the single
//   timer update path, except while an expiring slot waits for room, and
//   holds later requests in the queue; a zero tick skips the walk
// reset
//   synchronous active-low rst_n: all timers inactive, all counters stopped,
//   no slots allocated, queue and result register empty
// stalls
//   while out_stall is high the result is held; the back end keeps working
//   until it needs the result register, and the queue absorbs two requests
//   before in_stall rises
// ----------------------------------------------------------------------------
module oneshot_timer_and_counter_bank_unit import otcb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [VALUE_W-1:0]    in_period,
  input  logic [ELAPSED_W-1:0]  in_elapsed,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_kind,
  output logic [SLOT_W-1:0]     out_result_slot,
  output logic [VALUE_W-1:0]    out_count_value,
  output logic                  out_bad_slot,
  output logic                  out_last
);

  // front to queue
  logic      q_push;
  logic      q_full;
  otcb_cmd_t push_cmd;

  // queue to back
  logic      q_pop;
  logic      q_not_empty;
  otcb_cmd_t head_cmd;

  // classify requests (slot range check, zero tick)
  otcb_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_slot     (in_slot),
    .in_period   (in_period),
    .in_elapsed  (in_elapsed),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  // decouples input transfers from the tick walk
  otcb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  // slot state, timer walk and result register
  otcb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_cmd           (head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_result_slot (out_result_slot),
    .out_count_value (out_count_value),
    .out_bad_slot    (out_bad_slot),
    .out_last        (out_last)
  );

endmodule

/* rtl/otcb_front.sv */
// ----------------------------------------------------------------------------
// otcb_front
// accepts request transfers and classifies them for the command queue
// ----------------------------------------------------------------------------
module otcb_front import otcb_pkg::*; (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [VALUE_W-1:0]    in_period,
  input  logic [ELAPSED_W-1:0]  in_elapsed,
  input  logic                  q_full,
  output logic                  q_push,
  output otcb_cmd_t             q_cmd
);

  req_e_t req;
  logic   tbad;
  logic   cbad;

  assign req  = req_e_t'(in_req_type);
  assign tbad = in_slot >= SLOT_W'(TIMER_SLOTS);
  assign cbad = in_slot >= SLOT_W'(COUNTER_SLOTS);

  always_comb begin
    q_cmd.req       = req;
    q_cmd.slot      = in_slot;
    q_cmd.period    = in_period;
    q_cmd.elapsed   = in_elapsed;
    q_cmd.tick_live = in_elapsed != '0;
    unique case (req)
      REQ_START_TIMER, REQ_STOP_TIMER: begin
        q_cmd.bad = tbad;
      end
      REQ_START_COUNTER, REQ_STOP_COUNTER, REQ_READ_COUNTER: begin
        q_cmd.bad = cbad;
      end
      default: begin
        q_cmd.bad = 1'b0;
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

/* rtl/otcb_queue.sv */
// ----------------------------------------------------------------------------
// otcb_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module otcb_queue import otcb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  otcb_cmd_t  push_cmd,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output otcb_cmd_t  head_cmd
);

  otcb_cmd_t           entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_nxt;
  logic                do_push;
  logic                do_pop;

  assign full      = count_r == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head_cmd  = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/otcb_back.sv */
// ----------------------------------------------------------------------------
// otcb_back
// carries out commands: slot state, timer walk on ticks, result register
// ----------------------------------------------------------------------------
module otcb_back import otcb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_not_empty,
  input  otcb_cmd_t             q_cmd,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_kind,
  output logic [SLOT_W-1:0]     out_result_slot,
  output logic [VALUE_W-1:0]    out_count_value,
  output logic                  out_bad_slot,
  output logic                  out_last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_ACK
  } state_t;

  state_t                 state_r, state_nxt;
  logic [VALUE_W-1:0]     timer_r   [TIMER_SLOTS];
  logic [VALUE_W-1:0]     timer_nxt [TIMER_SLOTS];
  logic [VALUE_W-1:0]     cnt_r     [COUNTER_SLOTS];
  logic [VALUE_W-1:0]     cnt_nxt   [COUNTER_SLOTS];
  logic [TCNT_W-1:0]      timers_used_r, timers_used_nxt;
  logic [CCNT_W-1:0]      counters_used_r, counters_used_nxt;
  logic [TIDX_W-1:0]      walk_idx_r, walk_idx_nxt;
  logic [ELAPSED_W-1:0]   elapsed_r, elapsed_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic [VALUE_W-1:0]     out_value_r, out_value_nxt;
  logic                   out_bad_r, out_bad_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   out_free;
  logic [TIDX_W-1:0]      tslot;
  logic [CIDX_W-1:0]      cslot;
  logic [VALUE_W-1:0]     walk_val;
  logic [VALUE_W-1:0]     walk_dec;
  logic                   walk_live;
  logic                   walk_expire;
  logic [VALUE_W-1:0]     elapsed_ext;

  assign out_free    = !out_valid_r || !out_stall;
  assign tslot       = q_cmd.slot[TIDX_W-1:0];
  assign cslot       = q_cmd.slot[CIDX_W-1:0];
  assign elapsed_ext = {{(VALUE_W - ELAPSED_W){1'b0}}, elapsed_r};

  // one timer slot per cycle during a tick, unless an expiring slot waits
  assign walk_val    = timer_r[walk_idx_r];
  assign walk_live   = ({{(TCNT_W - TIDX_W + 1){1'b0}}, walk_idx_r} <
                        {1'b0, timers_used_r}) && (walk_val != IDLE_MARK);
  assign walk_dec    = (walk_val >= elapsed_ext) ? walk_val - elapsed_ext : '0;
  assign walk_expire = walk_live && (walk_dec == '0);

  always_comb begin
    state_nxt         = state_r;
    timer_nxt         = timer_r;
    cnt_nxt           = cnt_r;
    timers_used_nxt   = timers_used_r;
    counters_used_nxt = counters_used_r;
    walk_idx_nxt      = walk_idx_r;
    elapsed_nxt       = elapsed_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_kind_nxt      = out_kind_r;
    out_slot_nxt      = out_slot_r;
    out_value_nxt     = out_value_r;
    out_bad_nxt       = out_bad_r;
    out_last_nxt      = out_last_r;
    q_pop             = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_not_empty && out_free) begin
          q_pop         = 1'b1;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ACK;
          out_slot_nxt  = q_cmd.slot;
          out_value_nxt = '0;
          out_bad_nxt   = q_cmd.bad;
          out_last_nxt  = 1'b1;
          unique case (q_cmd.req)
            REQ_NEW_TIMER: begin
              out_slot_nxt = NO_SLOT;
              if (timers_used_r < TCNT_W'(TIMER_SLOTS)) begin
                out_slot_nxt    = SLOT_W'(timers_used_r);
                timers_used_nxt = timers_used_r + 1'b1;
              end
            end
            REQ_START_TIMER: begin
              if (!q_cmd.bad) begin
                timer_nxt[tslot] = q_cmd.period;
              end
            end
            REQ_STOP_TIMER: begin
              if (!q_cmd.bad) begin
                timer_nxt[tslot] = IDLE_MARK;
              end
            end
            REQ_NEW_COUNTER: begin
              out_slot_nxt = NO_SLOT;
              if (counters_used_r < CCNT_W'(COUNTER_SLOTS)) begin
                out_slot_nxt      = SLOT_W'(counters_used_r);
                counters_used_nxt = counters_used_r + 1'b1;
              end
            end
            REQ_START_COUNTER: begin
              if (!q_cmd.bad) begin
                cnt_nxt[cslot] = '0;
              end
            end
            REQ_STOP_COUNTER: begin
              if (!q_cmd.bad) begin
                cnt_nxt[cslot] = IDLE_MARK;
              end
            end
            REQ_READ_COUNTER: begin
              if (!q_cmd.bad) begin
                out_value_nxt = cnt_r[cslot];
              end
            end
            REQ_TICK: begin
              out_slot_nxt = '0;
              if (q_cmd.tick_live) begin
                // counters advance together; the timers are walked next
                for (int i = 0; i < COUNTER_SLOTS; i++) begin
                  if ((i < int'(counters_used_r)) && (cnt_r[i] != IDLE_MARK)) begin
                    cnt_nxt[i] = cnt_r[i] +
                      {{(VALUE_W - ELAPSED_W){1'b0}}, q_cmd.elapsed};
                  end
                end
                out_valid_nxt = out_valid_r && out_stall;
                out_kind_nxt  = out_kind_r;
                out_slot_nxt  = out_slot_r;
                out_value_nxt = out_value_r;
                out_bad_nxt   = out_bad_r;
                out_last_nxt  = out_last_r;
                elapsed_nxt   = q_cmd.elapsed;
                walk_idx_nxt  = '0;
                state_nxt     = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_WALK: begin
        // an expiring slot waits for room in the result register
        if (!walk_expire || out_free) begin
          if (walk_live) begin
            timer_nxt[walk_idx_r] = walk_expire ? IDLE_MARK : walk_dec;
          end
          if (walk_expire) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_EXPIRED;
            out_slot_nxt  = SLOT_W'(walk_idx_r);
            out_value_nxt = '0;
            out_bad_nxt   = 1'b0;
            out_last_nxt  = 1'b0;
          end
          if (walk_idx_r == TIDX_W'(TIMER_SLOTS - 1)) begin
            state_nxt = S_ACK;
          end else begin
            walk_idx_nxt = walk_idx_r + 1'b1;
          end
        end
      end

      S_ACK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ACK;
          out_slot_nxt  = '0;
          out_value_nxt = '0;
          out_bad_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      timers_used_r   <= '0;
      counters_used_r <= '0;
      out_valid_r     <= 1'b0;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        timer_r[i] <= IDLE_MARK;
      end
      for (int i = 0; i < COUNTER_SLOTS; i++) begin
        cnt_r[i] <= IDLE_MARK;
      end
    end else begin
      state_r         <= state_nxt;
      timers_used_r   <= timers_used_nxt;
      counters_used_r <= counters_used_nxt;
      out_valid_r     <= out_valid_nxt;
      timer_r         <= timer_nxt;
      cnt_r           <= cnt_nxt;
    end
    walk_idx_r  <= walk_idx_nxt;
    elapsed_r   <= elapsed_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_value_r <= out_value_nxt;
    out_bad_r   <= out_bad_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_result_slot = out_slot_r;
  assign out_count_value = out_value_r;
  assign out_bad_slot    = out_bad_r;
  assign out_last        = out_last_r;

endmodule

/* dv/tb_oneshot_timer_and_counter_bank_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_oneshot_timer_and_counter_bank_unit
// self-checking bench for the one-shot timer and counter bank: a directed
// table of requests, a random mix, then a long tick run that carries the
// counters up to and past the stopped mark; every result is compared with
// a typed-in answer or a cycle-free model of the bank kept inside the bench
// ----------------------------------------------------------------------------
module tb_oneshot_timer_and_counter_bank_unit import otcb_pkg::*; ();

  // one result as seen on the out_* channel
  typedef struct packed {
    logic                 kind;
    logic [SLOT_W-1:0]    rslot;
    logic [VALUE_W-1:0]   count;
    logic                 bad;
    logic                 last;
  } bank_result_t;

  // one row of the directed table; want is only used when typed is set
  typedef struct packed {
    req_e_t                 req;
    logic [SLOT_W-1:0]      slot;
    logic [VALUE_W-1:0]     period;
    logic [ELAPSED_W-1:0]   elapsed;
    logic                   typed;
    bank_result_t           want;
  } bank_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_MIX    = 40;
  localparam int HOLD_CYCLES   = 150;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [REQ_W-1:0]      in_req_type;
  logic [SLOT_W-1:0]     in_slot;
  logic [VALUE_W-1:0]    in_period;
  logic [ELAPSED_W-1:0]  in_elapsed;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_kind;
  logic [SLOT_W-1:0]     out_result_slot;
  logic [VALUE_W-1:0]    out_count_value;
  logic                  out_bad_slot;
  logic                  out_last;

  oneshot_timer_and_counter_bank_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_slot         (in_slot),
    .in_period       (in_period),
    .in_elapsed      (in_elapsed),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_result_slot (out_result_slot),
    .out_count_value (out_count_value),
    .out_bad_slot    (out_bad_slot),
    .out_last        (out_last)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model state of the bank
  logic [VALUE_W-1:0] timer_left  [TIMER_SLOTS];
  logic [VALUE_W-1:0] counter_now [COUNTER_SLOTS];
  int                 timers_handed;
  int                 counters_handed;

  // results still owed by the bank, oldest first
  bank_result_t bank_results_due [$];

  int mismatches      = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int expiries_seen   = 0;
  bit steady_run      = 1'b0;  // no idling on either side while set

  // directed table: error codes, extremes and the first allocations are typed
  // in; rows whose answer depends on ticking come from the model
  bank_row_t directed_rows [DIRECTED_ROWS] = '{
    // stored entry of an unallocated counter reads as stopped after reset
    '{REQ_READ_COUNTER,  8'd0,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd0,   IDLE_MARK, 1'b0, 1'b1}},
    // out-of-range read, ignored fields at their top values
    '{REQ_READ_COUNTER,  8'd255, 16'hFFFF,   8'd255, 1'b1,
      '{KIND_ACK, 8'd255, 16'd0,     1'b1, 1'b1}},
    // first slot beyond the timer bank
    '{REQ_START_TIMER,   8'd8,   16'h1234,   8'd0,   1'b1,
      '{KIND_ACK, 8'd8,   16'd0,     1'b1, 1'b1}},
    '{REQ_STOP_TIMER,    8'd255, 16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd255, 16'd0,     1'b1, 1'b1}},
    '{REQ_START_COUNTER, 8'd8,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd8,   16'd0,     1'b1, 1'b1}},
    // zero tick gives only the closing acknowledge
    '{REQ_TICK,          8'd0,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd0,   16'd0,     1'b0, 1'b1}},
    '{REQ_NEW_TIMER,     8'd0,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd0,   16'd0,     1'b0, 1'b1}},
    // zero period: active at 0, expires on the next nonzero tick
    '{REQ_START_TIMER,   8'd0,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd0,   16'd0,     1'b0, 1'b1}},
    // unallocated timer in range: stored, not ticked until allocated
    '{REQ_START_TIMER,   8'd7,   16'd5,      8'd0,   1'b1,
      '{KIND_ACK, 8'd7,   16'd0,     1'b0, 1'b1}},
    '{REQ_NEW_COUNTER,   8'd0,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd0,   16'd0,     1'b0, 1'b1}},
    '{REQ_START_COUNTER, 8'd0,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd0,   16'd0,     1'b0, 1'b1}},
    '{REQ_START_COUNTER, 8'd3,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd3,   16'd0,     1'b0, 1'b1}},
    // full tick: timer 0 expires, counter 0 moves, counter 3 does not
    '{REQ_TICK,          8'd0,   16'd0,      8'd255, 1'b0, '0},
    '{REQ_READ_COUNTER,  8'd0,   16'd0,      8'd0,   1'b0, '0},
    // top period leaves the timer inactive
    '{REQ_START_TIMER,   8'd0,   16'hFFFF,   8'd0,   1'b1,
      '{KIND_ACK, 8'd0,   16'd0,     1'b0, 1'b1}},
    '{REQ_STOP_COUNTER,  8'd0,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd0,   16'd0,     1'b0, 1'b1}},
    '{REQ_STOP_TIMER,    8'd0,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd0,   16'd0,     1'b0, 1'b1}},
    // fill the timer bank
    '{REQ_NEW_TIMER,     8'd0,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd1,   16'd0,     1'b0, 1'b1}},
    '{REQ_NEW_TIMER,     8'd0,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd2,   16'd0,     1'b0, 1'b1}},
    '{REQ_NEW_TIMER,     8'd0,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd3,   16'd0,     1'b0, 1'b1}},
    '{REQ_NEW_TIMER,     8'd0,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd4,   16'd0,     1'b0, 1'b1}},
    '{REQ_NEW_TIMER,     8'd0,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd5,   16'd0,     1'b0, 1'b1}},
    '{REQ_NEW_TIMER,     8'd0,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd6,   16'd0,     1'b0, 1'b1}},
    '{REQ_NEW_TIMER,     8'd0,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, 8'd7,   16'd0,     1'b0, 1'b1}},
    // bank full
    '{REQ_NEW_TIMER,     8'd0,   16'd0,      8'd0,   1'b1,
      '{KIND_ACK, NO_SLOT, 16'd0,    1'b0, 1'b1}}
  };

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic clear_bank_model();
    int k;
    for (k = 0; k < TIMER_SLOTS; k++)
      timer_left[k] = IDLE_MARK;
    for (k = 0; k < COUNTER_SLOTS; k++)
      counter_now[k] = IDLE_MARK;
    timers_handed   = 0;
    counters_handed = 0;
  endtask

  // applies one accepted request to the model bank; when record is set the
  // results it causes are queued
  task automatic predict_bank_request(input req_e_t r, input logic [SLOT_W-1:0] s,
                                      input logic [VALUE_W-1:0] p,
                                      input logic [ELAPSED_W-1:0] e, input bit record);
    bank_result_t res;
    bank_result_t gone;
    bit           tbad;
    bit           cbad;
    int           k;
    tbad = (s >= TIMER_SLOTS);
    cbad = (s >= COUNTER_SLOTS);
    res  = '{KIND_ACK, s, 16'd0, 1'b0, 1'b1};
    case (r)
      REQ_NEW_TIMER: begin
        res.rslot = NO_SLOT;
        if (timers_handed < TIMER_SLOTS) begin
          res.rslot = SLOT_W'(timers_handed);
          timers_handed++;
        end
      end
      REQ_START_TIMER: begin
        res.bad = tbad;
        if (!tbad) timer_left[s] = p;
      end
      REQ_STOP_TIMER: begin
        res.bad = tbad;
        if (!tbad) timer_left[s] = IDLE_MARK;
      end
      REQ_NEW_COUNTER: begin
        res.rslot = NO_SLOT;
        if (counters_handed < COUNTER_SLOTS) begin
          res.rslot = SLOT_W'(counters_handed);
          counters_handed++;
        end
      end
      REQ_START_COUNTER: begin
        res.bad = cbad;
        if (!cbad) counter_now[s] = '0;
      end
      REQ_STOP_COUNTER: begin
        res.bad = cbad;
        if (!cbad) counter_now[s] = IDLE_MARK;
      end
      REQ_READ_COUNTER: begin
        res.bad = cbad;
        if (!cbad) res.count = counter_now[s];
      end
      default: begin
        res.rslot = '0;
        if (e != '0) begin
          for (k = 0; k < timers_handed; k++) begin
            if (timer_left[k] != IDLE_MARK) begin
              if (timer_left[k] <= VALUE_W'(e)) begin
                timer_left[k] = IDLE_MARK;
                gone = '{KIND_EXPIRED, SLOT_W'(k), 16'd0, 1'b0, 1'b0};
                if (record) bank_results_due.push_back(gone);
              end else begin
                timer_left[k] = timer_left[k] - VALUE_W'(e);
              end
            end
          end
          for (k = 0; k < counters_handed; k++) begin
            if (counter_now[k] != IDLE_MARK)
              counter_now[k] = counter_now[k] + VALUE_W'(e);
          end
        end
      end
    endcase
    if (record) bank_results_due.push_back(res);
  endtask

  // offers one request, holds it until the transfer, then updates the model
  task automatic offer_request(input req_e_t r, input logic [SLOT_W-1:0] s,
                               input logic [VALUE_W-1:0] p,
                               input logic [ELAPSED_W-1:0] e,
                               input bit typed, input bank_result_t want);
    while (!steady_run && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= r;
    in_slot     <= s;
    in_period   <= p;
    in_elapsed  <= e;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    requests_sent++;
    // typed rows carry their answer; the model only tracks state for them
    predict_bank_request(r, s, p, e, !typed);
    if (typed) bank_results_due.push_back(want);
  endtask

  // sender pause: nothing offered until every owed result has come
  task automatic drain_results();
    in_valid <= 1'b0;
    while (bank_results_due.size() != 0) @(posedge clk);
  endtask

  // random request with mostly in-range slots and small periods and ticks
  task automatic pick_random(output req_e_t r, output logic [SLOT_W-1:0] s,
                             output logic [VALUE_W-1:0] p,
                             output logic [ELAPSED_W-1:0] e);
    int w;
    w = $urandom_range(0, 99);
    if (w < 34)      r = REQ_TICK;
    else if (w < 52) r = REQ_START_TIMER;
    else if (w < 58) r = REQ_STOP_TIMER;
    else if (w < 63) r = REQ_NEW_TIMER;
    else if (w < 68) r = REQ_NEW_COUNTER;
    else if (w < 76) r = REQ_START_COUNTER;
    else if (w < 81) r = REQ_STOP_COUNTER;
    else             r = REQ_READ_COUNTER;
    if ($urandom_range(0, 9) == 0) s = SLOT_W'($urandom_range(TIMER_SLOTS, 255));
    else                           s = SLOT_W'($urandom_range(0, TIMER_SLOTS - 1));
    case ($urandom_range(0, 9))
      0:       p = IDLE_MARK;
      1, 2:    p = VALUE_W'($urandom);
      default: p = VALUE_W'($urandom_range(0, 40));
    endcase
    case ($urandom_range(0, 9))
      0:       e = '0;
      1, 2, 3: e = ELAPSED_W'($urandom);
      default: e = ELAPSED_W'($urandom_range(1, 8));
    endcase
  endtask

  // result side: checks each transfer, idles at random, and once holds off
  // for a long stretch so the queue fills and in_stall rises
  initial begin
    bank_result_t want;
    int           hold_left;
    bit           hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        results_checked++;
        if (out_kind === KIND_EXPIRED) expiries_seen++;
        if (bank_results_due.size() == 0) begin
          flag_mismatch($sformatf("result kind %0d slot %0d with nothing owed",
                                  out_kind, out_result_slot));
        end else begin
          want = bank_results_due.pop_front();
          if (out_kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
          if (out_result_slot !== want.rslot)
            flag_mismatch($sformatf("result_slot %0d, want %0d",
                                    out_result_slot, want.rslot));
          if (out_count_value !== want.count)
            flag_mismatch($sformatf("count_value %0d, want %0d",
                                    out_count_value, want.count));
          if (out_bad_slot !== want.bad)
            flag_mismatch($sformatf("bad_slot %0d, want %0d", out_bad_slot, want.bad));
          if (out_last !== want.last)
            flag_mismatch($sformatf("last %0d, want %0d", out_last, want.last));
        end
      end
      // long back-pressure once the random mix is under way
      if (!hold_done && results_checked >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady_run && ($urandom_range(0, 99) < 7);
      end
    end
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("timeout with %0d results still owed", bank_results_due.size());
    $display("tb_oneshot_timer_and_counter_bank_unit failed");
    $finish;
  end

  // request side and run sequence
  initial begin
    req_e_t                 r;
    logic [SLOT_W-1:0]      s;
    logic [VALUE_W-1:0]     p;
    logic [ELAPSED_W-1:0]   e;
    int                     n;
    int                     k;

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_NEW_TIMER;
    in_slot     <= '0;
    in_period   <= '0;
    in_elapsed  <= '0;
    clear_bank_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (k = 0; k < DIRECTED_ROWS; k++)
      offer_request(directed_rows[k].req, directed_rows[k].slot,
                    directed_rows[k].period, directed_rows[k].elapsed,
                    directed_rows[k].typed, directed_rows[k].want);
    drain_results();

    // random mix: the long receiver hold falls in here
    for (n = 0; n < RANDOM_MIX; n++) begin
      pick_random(r, s, p, e);
      offer_request(r, s, p, e, 1'b0, '0);
    end
    drain_results();

    // long tick run: fill both banks, start half the counters one tick ahead
    // of the rest; 257 full ticks land the first half exactly on the stopped
    // mark, then random ticks wrap the second half past the top
    for (k = 0; k < COUNTER_SLOTS + 1; k++)
      offer_request(REQ_NEW_COUNTER, SLOT_W'($urandom), VALUE_W'($urandom),
                    ELAPSED_W'($urandom), 1'b0, '0);
    for (k = 0; k < TIMER_SLOTS + 1; k++)
      offer_request(REQ_NEW_TIMER, SLOT_W'($urandom), VALUE_W'($urandom),
                    ELAPSED_W'($urandom), 1'b0, '0);
    for (k = 0; k < COUNTER_SLOTS / 2; k++)
      offer_request(REQ_START_COUNTER, SLOT_W'(k), '0, '0, 1'b0, '0);
    offer_request(REQ_TICK, '0, '0, 8'd255, 1'b0, '0);
    for (k = COUNTER_SLOTS / 2; k < COUNTER_SLOTS; k++)
      offer_request(REQ_START_COUNTER, SLOT_W'(k), '0, '0, 1'b0, '0);
    steady_run <= 1'b1;
    for (n = 0; n < 256; n++) begin
      if (n == 100) steady_run <= 1'b0;
      // timer starts and reads leave the counters alone
      case ($urandom_range(0, 7))
        0: offer_request(REQ_READ_COUNTER, SLOT_W'($urandom_range(0, COUNTER_SLOTS - 1)),
                         '0, '0, 1'b0, '0);
        1: offer_request(REQ_START_TIMER, SLOT_W'($urandom_range(0, TIMER_SLOTS - 1)),
                         VALUE_W'($urandom_range(1, 3000)), '0, 1'b0, '0);
        default: ;
      endcase
      offer_request(REQ_TICK, SLOT_W'($urandom), VALUE_W'($urandom), 8'd255, 1'b0, '0);
    end
    for (n = 0; n < 30; n++) begin
      if ($urandom_range(0, 2) == 0)
        offer_request(REQ_READ_COUNTER, SLOT_W'($urandom_range(0, COUNTER_SLOTS - 1)),
                      '0, '0, 1'b0, '0);
      offer_request(REQ_TICK, '0, '0, ELAPSED_W'($urandom_range(1, 255)), 1'b0, '0);
    end
    for (k = 0; k < COUNTER_SLOTS; k++)
      offer_request(REQ_READ_COUNTER, SLOT_W'(k), '0, '0, 1'b0, '0);

    // wind down: all owed results, then a few tick walks worth of quiet
    drain_results();
    repeat (4 * (TIMER_SLOTS + 2)) @(posedge clk);
    if (bank_results_due.size() != 0)
      flag_mismatch($sformatf("%0d results never came", bank_results_due.size()));

    $display("covered %0d requests (%0d from the table), %0d results, %0d expiries",
             requests_sent, DIRECTED_ROWS, results_checked, expiries_seen);
    $display("incl. full banks, bad slots, zero ticks, counters on and past the top");
    if (mismatches == 0) begin
      $display("tb_oneshot_timer_and_counter_bank_unit passed");
    end else begin
      $display("tb_oneshot_timer_and_counter_bank_unit failed");
    end
    $finish;
  end

endmodule
